[src/rgb_row_resampler_macros.svh]
// Assertion helpers shared by the resampler sources.
`ifndef RGB_ROW_RESAMPLER_MACROS_SVH
`define RGB_ROW_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rrr_pkg.sv]
`timescale 1ns / 1ps
package rrr_pkg;
	localparam int CFG_W         = 13;
	localparam int PIX_W         = 8;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int WEIGHT_DEF    = 12;
	localparam int RESULT_CAP    = 64;

	// Register indexes on the configuration port
	localparam logic REG_SRC_WIDTH = 1'b0;
	localparam logic REG_DST_WIDTH = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

[src/rrr_div.sv]
`timescale 1ns / 1ps
module rrr_div import rrr_pkg::*; #(
	parameter int NW = 33,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output div_stat_t     stat
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] qs_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	// Restoring division, one quotient bit per cycle
	assign trial = {rem_q, qs_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qs_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				qs_q  <= {qs_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				qs_q  <= {qs_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo       = qs_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

[src/rgb_row_resampler.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Handshake
// s_*       in   tdata: red_in, green_in, blue_in          tvalid/tready
// m_*       out  tdata: red, green, blue; tlast: last of   tvalid/tready
//                run; tuser: row_end, config_error
// cfg_*     in   cfg_index selects width, cfg_data value    cfg_we
//
// One source pixel at a time. Equal widths and downscale without a finished
// pixel need no division; downscale with one runs 4 serial divisions of
// NW = 21+WEIGHT_BITS bits plus control. Upscale runs one division per
// result on the one bit-serial divider.
// Reset clears widths to 1 and all row state; the row also restarts on any
// configuration write. A stalled output holds the register; input waits.
`include "rgb_row_resampler_macros.svh"
module rgb_row_resampler import rrr_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int WEIGHT_BITS = WEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
	output logic             m_tlast,
	output logic [1:0]       m_tuser,   // [0] row_end, [1] config_error
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int ONE_W = WEIGHT_BITS + 1;
	localparam int WS_W  = CFG_W + WEIGHT_BITS;
	localparam int SUM_W = PIX_W + WS_W;
	localparam int BL_W  = PIX_W + WEIGHT_BITS + 1;
	localparam int PR_W  = PIX_W + ONE_W;
	localparam int CNT_W = $clog2(RESULT_CAP) + 1;
	localparam int CMP_W = CFG_W + CNT_W;
	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << WEIGHT_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DSTART = 3'd1;
	localparam logic [2:0] ST_DWAIT  = 3'd2;
	localparam logic [2:0] ST_USTART = 3'd3;
	localparam logic [2:0] ST_UWAIT  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] src_w_q, dst_w_q;
	logic [CFG_W-1:0] phase_q, spos_q, dpos_q;
	logic [SUM_W-1:0] rsum_q, gsum_q, bsum_q;
	logic [WS_W-1:0]  wsum_q;
	logic [7:0]       pr_q, pg_q, pb_q;     // previous pixel
	logic [7:0]       cr_q, cg_q, cb_q;     // pixel at work
	logic [1:0]       chan_q;
	logic [ONE_W-1:0] q_q;
	logic [7:0]       qr_q, qg_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [2:0] delta_q;
	logic [7:0]       res_r_q, res_g_q, res_b_q;
	logic             res_rend_q, res_last_q, res_err_q, cont_q, commit_q;
	logic             m_tvalid_q, m_tlast_q;
	logic [23:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic             cfg_bad, in_acc, out_free, div_start, do_commit;
	logic [SUM_W-1:0] div_num, quo;
	logic [WS_W-1:0]  div_den;
	div_stat_t        div_st;
	logic [ONE_W-1:0] qcl, pinv;
	logic [7:0]       br, bgc, bb, blr, blg, blb, cmt_r, cmt_g, cmt_b;
	logic [CFG_W:0]   ph_dn, ph_up, ph_upn, dpos_inc;
	logic             wrap, up_cont;
	logic signed [2:0] delta_n;
	logic [CFG_W-1:0] unit, phase_upn;
	logic [SUM_W-1:0] phase_sh;
	logic [CFG_W:0]   spos_inc;

	// Unusable configuration: zero or oversized width, or too many results per pixel
	always_comb begin
		cfg_bad = 1'b0;
		if (src_w_q == '0 || dst_w_q == '0) cfg_bad = 1'b1;
		if (32'(src_w_q) > 32'(MAX_WIDTH) || 32'(dst_w_q) > 32'(MAX_WIDTH)) cfg_bad = 1'b1;
		if (src_w_q < dst_w_q) begin
			if (src_w_q == CFG_W'(1)) begin
				if (32'(dst_w_q) > 32'(RESULT_CAP)) cfg_bad = 1'b1;
			end else if (CMP_W'(dst_w_q - CFG_W'(1)) >
			             CMP_W'(src_w_q - CFG_W'(1)) * CMP_W'(RESULT_CAP)) begin
				cfg_bad = 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign unit     = dst_w_q - CFG_W'(1);
	assign phase_sh = SUM_W'({phase_q, {WEIGHT_BITS{1'b0}}});

	// Divider operand select: phase for weights, sums for the colour averages
	always_comb begin
		div_start = (state_q == ST_DSTART) || (state_q == ST_USTART);
		div_num   = phase_sh;
		div_den   = WS_W'(dst_w_q);
		if (state_q == ST_USTART) begin
			div_den = WS_W'(unit);
		end else begin
			case (chan_q)
				2'd1: begin div_num = rsum_q; div_den = wsum_q; end
				2'd2: begin div_num = gsum_q; div_den = wsum_q; end
				2'd3: begin div_num = bsum_q; div_den = wsum_q; end
				default: begin div_num = phase_sh; div_den = WS_W'(dst_w_q); end
			endcase
		end
	end

	rrr_div #(.NW(SUM_W), .DW(WS_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (quo),
		.stat  (div_st)
	);

	// Clamp weight, then blend base and current pixel
	assign qcl  = (quo > SUM_W'(ONE)) ? ONE : quo[ONE_W-1:0];
	assign pinv = ONE - qcl;
	assign br   = (phase_q != '0) ? pr_q : cr_q;
	assign bgc  = (phase_q != '0) ? pg_q : cg_q;
	assign bb   = (phase_q != '0) ? pb_q : cb_q;

	function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
	                                     input logic [ONE_W-1:0] p);
		logic [BL_W-1:0] mix;
		mix = BL_W'(a) * BL_W'(ONE - p) + BL_W'(b) * BL_W'(p);
		return (p == '0) ? a : mix[WEIGHT_BITS +: 8];
	endfunction

	assign blr = blend(br, cr_q, qcl);
	assign blg = blend(bgc, cg_q, qcl);
	assign blb = blend(bb, cb_q, qcl);

	// Upscale step: advance phase, track where the base pixel sits against this one
	assign ph_up     = {1'b0, phase_q} + {1'b0, src_w_q - CFG_W'(1)};
	assign wrap      = ph_up >= {1'b0, unit};
	assign ph_upn    = wrap ? ph_up - {1'b0, unit} : ph_up;
	assign phase_upn = ph_upn[CFG_W-1:0];
	assign delta_n   = delta_q + (wrap ? 3'sd1 : 3'sd0);
	assign dpos_inc  = {1'b0, dpos_q} + (CFG_W+1)'(1);
	assign up_cont   = (dpos_inc < {1'b0, dst_w_q}) &&
	                   (cnt_q + CNT_W'(1) < CNT_W'(RESULT_CAP)) &&
	                   ((delta_n == 3'sd0 && phase_upn == '0) ||
	                    (delta_n == -3'sd1 && phase_upn != '0));
	assign ph_dn     = {1'b0, phase_q} + {1'b0, dst_w_q};

	// Row bookkeeping once a pixel is done
	always_comb begin
		do_commit = 1'b0;
		cmt_r = cr_q;
		cmt_g = cg_q;
		cmt_b = cb_q;
		if (state_q == ST_IDLE) begin
			cmt_r = s_tdata[7:0];
			cmt_g = s_tdata[15:8];
			cmt_b = s_tdata[23:16];
			if (in_acc && !cfg_bad) begin
				if (src_w_q > dst_w_q) do_commit = ph_dn < {1'b0, src_w_q};
				else if (src_w_q < dst_w_q) do_commit = dpos_q >= dst_w_q;
			end
		end else if (state_q == ST_EMIT) begin
			do_commit = out_free && !cont_q && commit_q;
		end
	end
	assign spos_inc = {1'b0, spos_q} + (CFG_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			src_w_q  <= CFG_W'(1);
			dst_w_q  <= CFG_W'(1);
			phase_q  <= '0;
			spos_q   <= '0;
			dpos_q   <= '0;
			rsum_q   <= '0;
			gsum_q   <= '0;
			bsum_q   <= '0;
			wsum_q   <= '0;
			pr_q     <= '0;
			pg_q     <= '0;
			pb_q     <= '0;
			chan_q   <= '0;
			cnt_q    <= '0;
			delta_q  <= '0;
			cont_q   <= 1'b0;
			commit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cfg_bad) begin
							// one error result, row state untouched
							res_r_q <= '0; res_g_q <= '0; res_b_q <= '0;
							res_rend_q <= 1'b0;
							res_last_q <= 1'b1;
							res_err_q  <= 1'b1;
							cont_q     <= 1'b0;
							commit_q   <= 1'b0;
							state_q    <= ST_EMIT;
						end else if (src_w_q == dst_w_q) begin
							// pass through
							res_r_q <= s_tdata[7:0];
							res_g_q <= s_tdata[15:8];
							res_b_q <= s_tdata[23:16];
							res_rend_q <= dpos_inc >= {1'b0, dst_w_q};
							res_last_q <= 1'b1;
							res_err_q  <= 1'b0;
							dpos_q     <= dpos_inc[CFG_W-1:0];
							cont_q     <= 1'b0;
							commit_q   <= 1'b1;
							state_q    <= ST_EMIT;
						end else if (src_w_q > dst_w_q) begin
							if (ph_dn >= {1'b0, src_w_q}) begin
								// boundary crossed: find the split weight first
								phase_q <= CFG_W'(ph_dn - {1'b0, src_w_q});
								chan_q  <= 2'd0;
								state_q <= ST_DSTART;
							end else begin
								phase_q <= ph_dn[CFG_W-1:0];
								rsum_q <= rsum_q + SUM_W'({s_tdata[7:0], {WEIGHT_BITS{1'b0}}});
								gsum_q <= gsum_q + SUM_W'({s_tdata[15:8], {WEIGHT_BITS{1'b0}}});
								bsum_q <= bsum_q + SUM_W'({s_tdata[23:16], {WEIGHT_BITS{1'b0}}});
								wsum_q <= wsum_q + WS_W'(ONE);
							end
						end else if (dpos_q < dst_w_q) begin
							delta_q <= (phase_q != '0) ? -3'sd1 : 3'sd0;
							cnt_q   <= '0;
							state_q <= ST_USTART;
						end
					end
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_st.done) begin
						case (chan_q)
							2'd0: begin
								// finishing pixel takes the remaining weight
								q_q    <= qcl;
								rsum_q <= rsum_q + SUM_W'(PR_W'(pinv) * PR_W'(cr_q));
								gsum_q <= gsum_q + SUM_W'(PR_W'(pinv) * PR_W'(cg_q));
								bsum_q <= bsum_q + SUM_W'(PR_W'(pinv) * PR_W'(cb_q));
								wsum_q <= wsum_q + WS_W'(pinv);
								chan_q <= 2'd1;
								state_q <= ST_DSTART;
							end
							2'd1: begin
								qr_q <= quo[7:0];
								chan_q <= 2'd2;
								state_q <= ST_DSTART;
							end
							2'd2: begin
								qg_q <= quo[7:0];
								chan_q <= 2'd3;
								state_q <= ST_DSTART;
							end
							default: begin
								// emit the average, seed sums with the carried-over part
								res_r_q <= (wsum_q == '0) ? 8'd0 : qr_q;
								res_g_q <= (wsum_q == '0) ? 8'd0 : qg_q;
								res_b_q <= (wsum_q == '0) ? 8'd0 : quo[7:0];
								res_rend_q <= dpos_inc >= {1'b0, dst_w_q};
								res_last_q <= 1'b1;
								res_err_q  <= 1'b0;
								dpos_q <= dpos_inc[CFG_W-1:0];
								rsum_q <= SUM_W'(PR_W'(q_q) * PR_W'(cr_q));
								gsum_q <= SUM_W'(PR_W'(q_q) * PR_W'(cg_q));
								bsum_q <= SUM_W'(PR_W'(q_q) * PR_W'(cb_q));
								wsum_q <= WS_W'(q_q);
								cont_q   <= 1'b0;
								commit_q <= 1'b1;
								chan_q   <= 2'd0;
								state_q  <= ST_EMIT;
							end
						endcase
					end
				end
				ST_USTART: state_q <= ST_UWAIT;
				ST_UWAIT: begin
					if (div_st.done) begin
						res_r_q <= blr;
						res_g_q <= blg;
						res_b_q <= blb;
						res_rend_q <= dpos_inc >= {1'b0, dst_w_q};
						res_last_q <= !up_cont;
						res_err_q  <= 1'b0;
						dpos_q  <= dpos_inc[CFG_W-1:0];
						cnt_q   <= cnt_q + CNT_W'(1);
						phase_q <= phase_upn;
						delta_q <= delta_n;
						cont_q   <= up_cont;
						commit_q <= 1'b1;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register frees up
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q <= cont_q ? ST_USTART : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (do_commit) begin
				pr_q <= cmt_r;
				pg_q <= cmt_g;
				pb_q <= cmt_b;
				if (spos_inc >= {1'b0, src_w_q}) begin
					phase_q <= '0; spos_q <= '0; dpos_q <= '0;
					rsum_q <= '0; gsum_q <= '0; bsum_q <= '0; wsum_q <= '0;
				end else begin
					spos_q <= spos_inc[CFG_W-1:0];
				end
			end

			// configuration write: store width, restart the row
			if (cfg_we) begin
				if (cfg_index == REG_SRC_WIDTH) src_w_q <= cfg_data;
				else if (cfg_index == REG_DST_WIDTH) dst_w_q <= cfg_data;
				phase_q <= '0; spos_q <= '0; dpos_q <= '0;
				rsum_q <= '0; gsum_q <= '0; bsum_q <= '0; wsum_q <= '0;
			end
		end
	end

	// Pixel at work, captured on input accept; output payload register, loaded with the transaction leaving EMIT
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			cr_q <= s_tdata[7:0];
			cg_q <= s_tdata[15:8];
			cb_q <= s_tdata[23:16];
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= {res_b_q, res_g_q, res_r_q};
			m_tlast_q <= res_last_q;
			m_tuser_q <= {res_err_q, res_rend_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	`ASSERT_IMP(a_err_zero, m_tvalid && m_tuser[1], m_tdata == '0 && m_tlast, "error result not blank")
	`ASSERT_IMP(a_div_wait, div_st.done, state_q == ST_DWAIT || state_q == ST_UWAIT, "stray divider result")
	`ASSERT_IMP(a_dest_bound, !cfg_bad, dpos_q <= dst_w_q, "destination position past row end")
	`ASSERT_IMP(a_run_cap, state_q == ST_UWAIT, cnt_q < CNT_W'(RESULT_CAP), "too many results for one pixel")
	`ASSERT_NXT(a_emit_load, state_q == ST_EMIT && out_free, m_tvalid, "result not presented")
endmodule

[verif/rgb_row_resampler_checker.sv]
`timescale 1ns / 1ps
module rgb_row_resampler_checker import rrr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [23:0]      s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [23:0]      m_tdata,
	input  logic             m_tlast,
	input  logic [1:0]       m_tuser,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               pending,
	output int               errors
);
	localparam longint unsigned ONE = 64'd1 << WEIGHT_DEF;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         run_last;
		bit         row_end;
		bit         cfg_err;
	} pixel_t;

	pixel_t pixel_q[$];

	longint unsigned src_w, dst_w, phase, red_acc, green_acc, blue_acc, weight_acc;
	longint unsigned last_pixel, src_pos, dst_pos;

	assign pending = pixel_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic clear_row();
		phase = 0;
		red_acc = 0;
		green_acc = 0;
		blue_acc = 0;
		weight_acc = 0;
		src_pos = 0;
		dst_pos = 0;
	endtask

	function automatic bit widths_unusable();
		if (src_w == 0 || dst_w == 0) return 1;
		if (src_w > MAX_WIDTH_DEF || dst_w > MAX_WIDTH_DEF) return 1;
		if (src_w < dst_w) begin
			if (src_w == 1) return dst_w > RESULT_CAP;
			return (dst_w - 1) > RESULT_CAP * (src_w - 1);
		end
		return 0;
	endfunction

	function automatic longint unsigned mix(input longint unsigned a, b, p);
		if (p == 0) return a;
		return (a * (ONE - p) + b * p) >> WEIGHT_DEF;
	endfunction

	task automatic add_pixel(input longint unsigned r, g, b, input bit rend);
		pixel_t px;
		px.red = r[7:0];
		px.green = g[7:0];
		px.blue = b[7:0];
		px.run_last = 0;
		px.row_end = rend;
		px.cfg_err = 0;
		pixel_q.push_back(px);
	endtask

	// Work out every destination pixel that one source pixel completes.
	task automatic resample_pixel(input logic [23:0] data);
		longint unsigned r, g, b, q, p, a, pr, pg, pb, unit, inc, k;
		longint base, need;
		int n;
		pixel_t px;
		r = data[7:0];
		g = data[15:8];
		b = data[23:16];
		k = src_pos;
		n = 0;
		if (widths_unusable()) begin
			px = '{red: 0, green: 0, blue: 0, run_last: 1, row_end: 0, cfg_err: 1};
			pixel_q.push_back(px);
			return;
		end
		if (src_w == dst_w) begin
			dst_pos++;
			add_pixel(r, g, b, dst_pos >= dst_w);
			n++;
		end else if (src_w > dst_w) begin
			phase += dst_w;
			if (phase >= src_w) begin
				phase -= src_w;
				q = (phase << WEIGHT_DEF) / dst_w;
				if (q > ONE) q = ONE;
				p = ONE - q;
				red_acc += p * r;
				green_acc += p * g;
				blue_acc += p * b;
				weight_acc += p;
				dst_pos++;
				if (weight_acc != 0)
					add_pixel(red_acc / weight_acc, green_acc / weight_acc,
						blue_acc / weight_acc, dst_pos >= dst_w);
				else
					add_pixel(0, 0, 0, dst_pos >= dst_w);
				n++;
				red_acc = q * r;
				green_acc = q * g;
				blue_acc = q * b;
				weight_acc = q;
			end else begin
				red_acc += r << WEIGHT_DEF;
				green_acc += g << WEIGHT_DEF;
				blue_acc += b << WEIGHT_DEF;
				weight_acc += ONE;
			end
		end else begin
			inc = src_w - 1;
			unit = dst_w - 1;
			pr = (last_pixel >> 16) & 8'hFF;
			pg = (last_pixel >> 8) & 8'hFF;
			pb = last_pixel & 8'hFF;
			base = longint'(k) - (phase > 0 ? 1 : 0);
			while (dst_pos < dst_w && n < RESULT_CAP) begin
				a = phase;
				p = (a << WEIGHT_DEF) / unit;
				if (p > ONE) p = ONE;
				dst_pos++;
				add_pixel(mix(a > 0 ? pr : r, r, p), mix(a > 0 ? pg : g, g, p),
					mix(a > 0 ? pb : b, b, p), dst_pos >= dst_w);
				n++;
				phase += inc;
				if (phase >= unit) begin
					phase -= unit;
					base++;
				end
				need = base + (phase > 0 ? 1 : 0);
				if (need != longint'(k)) break;
			end
		end
		last_pixel = (r << 16) | (g << 8) | b;
		if (k + 1 >= src_w) clear_row();
		else src_pos = k + 1;
		if (n > 0) pixel_q[pixel_q.size() - 1].run_last = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			src_w = 1;
			dst_w = 1;
			last_pixel = 0;
			clear_row();
			pixel_q.delete();
			errors = 0;
		end else begin
			// Compare first so a result never meets an expectation from this edge.
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: result transaction with nothing expected", $realtime);
					errors++;
				end else begin
					exp_px = pixel_q.pop_front();
					if (m_tdata[7:0] !== exp_px.red) report("red", m_tdata[7:0], exp_px.red);
					if (m_tdata[15:8] !== exp_px.green)
						report("green", m_tdata[15:8], exp_px.green);
					if (m_tdata[23:16] !== exp_px.blue)
						report("blue", m_tdata[23:16], exp_px.blue);
					if (m_tlast !== exp_px.run_last) report("tlast", m_tlast, exp_px.run_last);
					if (m_tuser[0] !== exp_px.row_end)
						report("row_end", m_tuser[0], exp_px.row_end);
					if (m_tuser[1] !== exp_px.cfg_err)
						report("config_error", m_tuser[1], exp_px.cfg_err);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_SRC_WIDTH) src_w = cfg_data;
				else dst_w = cfg_data;
				clear_row();
			end
			if (s_tvalid && s_tready) resample_pixel(s_tdata);
		end
	end
endmodule

[verif/rgb_row_resampler_test.sv]
`timescale 1ns / 1ps
module rgb_row_resampler_test;
	import rrr_pkg::*;

	// Generous: worst upscale items at 64 results under heavy stall.
	localparam int CYCLE_LIMIT = 3_000_000;
	// Drain time after the last result; covers a no-result downscale item.
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_ITEMS = 240;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             s_tvalid = 0;
	logic             s_tready;
	logic [23:0]      s_tdata = '0;   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
	logic             m_tvalid;
	logic             m_tready = 0;
	logic [23:0]      m_tdata;        // [7:0] red_out, [15:8] green_out, [23:16] blue_out
	logic             m_tlast;
	logic [1:0]       m_tuser;        // [0] row_end, [1] config_error
	logic             cfg_we = 0;
	logic             cfg_index = REG_SRC_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int pending, errors;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int phase_count = 0;
	int sent_random = 0;
	int cycles = 0;

	rgb_row_resampler u_top (.*);

	rgb_row_resampler_checker u_checker (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver back-pressure, redrawn every cycle at the falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Hold until every expected transaction has arrived, then let the block settle.
	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Offer one source pixel; leave tvalid high so the next pixel can follow back to back.
	task automatic send_pixel(input logic [23:0] px);
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 0;
			do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop idle, write both widths, then stream n pixels under this phase's idling mode.
	task automatic run_phase(input int src, input int dst, input int n, input bit pause_mid);
		logic [23:0] px;
		s_tvalid <= 0;
		wait_idle();
		case (phase_count % 4)
			0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_gap_pct = 77; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 77; end
			default: begin send_gap_pct = 22; recv_stall_pct = 22; end
		endcase
		phase_count++;
		cfg_we <= 1;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= CFG_W'(src);
		@(negedge clk);
		cfg_index <= REG_DST_WIDTH;
		cfg_data <= CFG_W'(dst);
		@(negedge clk);
		cfg_we <= 0;
		for (int i = 0; i < n; i++) begin
			// Mix in black and white pixels to hit the component extremes.
			case ($urandom_range(6))
				0: px = 24'h000000;
				1: px = 24'hFFFFFF;
				default: px = 24'($urandom);
			endcase
			if (pause_mid && i == n / 2) begin
				s_tvalid <= 0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			send_pixel(px);
		end
	endtask

	initial begin
		int src, dst, n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extreme widths, the error cases, pass-through.
		run_phase(3, 3, 7, 0);
		run_phase(4096, 1, 6, 0);
		run_phase(4096, 4096, 3, 0);
		run_phase(1, 64, 3, 1);
		run_phase(2, 65, 2, 0);
		run_phase(1, 65, 2, 0);
		run_phase(0, 5, 1, 0);
		run_phase(5, 0, 1, 0);
		run_phase(5000, 3, 1, 0);
		run_phase(1, 4096, 1, 0);

		// Random widths, mostly small so rows wrap often.
		while (sent_random < RANDOM_ITEMS) begin
			case ($urandom_range(3))
				0: begin src = $urandom_range(1, 12); dst = src; end
				1: begin src = $urandom_range(2, 40); dst = $urandom_range(1, src - 1); end
				default: begin
					src = $urandom_range(2, 12);
					dst = $urandom_range(src + 1, src + 14);
				end
			endcase
			n = $urandom_range(10, 30);
			run_phase(src, dst, n, phase_count == 13);
			sent_random += n;
		end

		s_tvalid <= 0;
		wait_idle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
